/* hdl/k_smallest_tracker_max_heap_top_macros.svh */
// ---------------------------------------------------------------------------
// k_smallest_tracker_max_heap_top_macros.svh
// Assertion shorthands used by the heap tracker RTL.
// ---------------------------------------------------------------------------
`ifndef K_SMALLEST_TRACKER_MAX_HEAP_TOP_MACROS_SVH
`define K_SMALLEST_TRACKER_MAX_HEAP_TOP_MACROS_SVH

// same-cycle implication, masked while in reset
`define KST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kst assertion failed");

// next-cycle implication, masked while in reset
`define KST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kst assertion failed");

`endif

/* hdl/kst_pkg.sv */
// ---------------------------------------------------------------------------
// kst_pkg
// Shared constants and types for the k-smallest max-heap tracker.
// ---------------------------------------------------------------------------
package kst_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 9;
  localparam int HELD_W = 9;
  localparam int LIM_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(256);
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // heap memory access issued by the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

endpackage

/* hdl/kst_ram.sv */
// ---------------------------------------------------------------------------
// kst_ram
// Generic RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module kst_ram #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* hdl/kst_ctrl.sv */
// ---------------------------------------------------------------------------
// kst_ctrl
// Heap sequencer: sift-up on insert, sift-down on root replace, query reply.
// ---------------------------------------------------------------------------
`include "k_smallest_tracker_max_heap_top_macros.svh"

module kst_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_operation,
  input  logic signed [kst_pkg::DATA_W-1:0]    in_value,
  input  logic [kst_pkg::CAP_W-1:0]            capacity,
  output kst_pkg::ram_req_t                    ram_req,
  input  logic [kst_pkg::DATA_W-1:0]           rdata_a,
  input  logic [kst_pkg::DATA_W-1:0]           rdata_b,
  output logic                                 out_valid,
  output logic signed [kst_pkg::DATA_W-1:0]    out_kth_value,
  output logic                                 out_is_empty,
  output logic [kst_pkg::HELD_W-1:0]           out_held_count
);

  localparam int AW   = kst_pkg::ADDR_W;
  localparam int DW   = kst_pkg::DATA_W;
  localparam int CW   = kst_pkg::CNT_W;
  localparam int LW   = kst_pkg::LIM_W;
  localparam int IX_W = kst_pkg::ADDR_W + 2;

  typedef enum logic [1:0] {S_IDLE, S_UP, S_DN, S_FIN} state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         par_r, par_nxt;
  logic signed [DW-1:0]  val_r, val_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic signed [DW-1:0]  root_r, root_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]  out_kth_r, out_kth_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic [kst_pkg::HELD_W-1:0] out_cnt_r, out_cnt_nxt;

  kst_pkg::ram_req_t     req;
  logic [LW-1:0]         limit;
  logic                  accept;
  logic signed [DW-1:0]  rd_a;
  logic signed [DW-1:0]  rd_b;
  logic [IX_W-1:0]       n_ix;
  logic [IX_W-1:0]       c1_ix;
  logic [IX_W-1:0]       c2_ix;
  logic [IX_W-1:0]       nc_ix;
  logic                  has2;
  logic                  pick2;
  logic [AW-1:0]         child;
  logic signed [DW-1:0]  child_val;

  assign accept = start && (state_r == S_IDLE);
  assign rd_a   = $signed(rdata_a);
  assign rd_b   = $signed(rdata_b);
  assign limit  = (LW'(capacity) > LW'(kst_pkg::DEPTH)) ? LW'(kst_pkg::DEPTH)
                                                         : LW'(capacity);

  // sift-down child selection
  assign n_ix      = IX_W'(fill_r);
  assign c1_ix     = IX_W'({pos_r, 1'b1});
  assign c2_ix     = c1_ix + IX_W'(1);
  assign has2      = c2_ix < n_ix;
  assign pick2     = has2 && (rd_a < rd_b);
  assign child     = pick2 ? c2_ix[AW-1:0] : c1_ix[AW-1:0];
  assign child_val = pick2 ? rd_b : rd_a;
  assign nc_ix     = IX_W'({child, 1'b1});

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    par_nxt       = par_r;
    val_nxt       = val_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    out_kth_nxt   = out_kth_r;
    out_empty_nxt = out_empty_r;
    out_cnt_nxt   = out_cnt_r;
    req           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == kst_pkg::OP_QUERY) begin
            out_valid_nxt = 1'b1;
            out_empty_nxt = (fill_r == '0);
            out_kth_nxt   = (fill_r == '0) ? $signed(kst_pkg::EMPTY_VALUE) : root_r;
            out_cnt_nxt   = kst_pkg::HELD_W'(fill_r);
          end else if (LW'(fill_r) < limit) begin
            val_nxt  = in_value;
            pos_nxt  = fill_r[AW-1:0];
            fill_nxt = fill_r + CW'(1);
            if (fill_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              par_nxt     = AW'((fill_r - CW'(1)) >> 1);
              req.raddr_a = par_nxt;
              state_nxt   = S_UP;
            end
          end else if ((fill_r != '0) && (in_value < root_r)) begin
            val_nxt = in_value;
            pos_nxt = '0;
            if (fill_r == CW'(1)) begin
              state_nxt = S_FIN;
            end else begin
              req.raddr_a = AW'(1);
              req.raddr_b = AW'(2);
              state_nxt   = S_DN;
            end
          end
        end
      end
      S_UP: begin
        req.we = 1'b1;
        req.waddr = pos_r;
        if (rd_a < val_r) begin
          // parent moves down, climb one level
          req.wdata = rdata_a;
          pos_nxt   = par_r;
          if (par_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            par_nxt     = (par_r - AW'(1)) >> 1;
            req.raddr_a = par_nxt;
          end
        end else begin
          req.wdata = val_r;
          state_nxt = S_IDLE;
        end
      end
      S_DN: begin
        req.we = 1'b1;
        req.waddr = pos_r;
        if (child_val > val_r) begin
          req.wdata = child_val;
          pos_nxt   = child;
          if (nc_ix < n_ix) begin
            req.raddr_a = nc_ix[AW-1:0];
            req.raddr_b = AW'(nc_ix + IX_W'(1));
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          req.wdata = val_r;
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        req.we    = 1'b1;
        req.waddr = pos_r;
        req.wdata = val_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // shadow copy of the root keeps queries and compares off the memory
    root_nxt = (req.we && (req.waddr == '0)) ? $signed(req.wdata) : root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    par_r       <= par_nxt;
    val_r       <= val_nxt;
    root_r      <= root_nxt;
    out_kth_r   <= out_kth_nxt;
    out_empty_r <= out_empty_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign ram_req        = req;
  assign out_valid      = out_valid_r;
  assign out_kth_value  = out_kth_r;
  assign out_is_empty   = out_empty_r;
  assign out_held_count = out_cnt_r;

  `KST_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(kst_pkg::DEPTH))
  `KST_ASSERT_IMP(a_idle_no_write, clk, rst_n, state_r == S_IDLE, !req.we)
  `KST_ASSERT_NXT(a_query_reply, clk, rst_n,
                  accept && (in_operation == kst_pkg::OP_QUERY), out_valid_r)
  `KST_ASSERT_NXT(a_fill_step, clk, rst_n, 1'b1,
                  (fill_r == $past(fill_r)) || (fill_r == $past(fill_r) + CW'(1)))

endmodule

/* hdl/k_smallest_tracker_max_heap_top.sv */
// ---------------------------------------------------------------------------
// k_smallest_tracker_max_heap_top
// Tracks the k smallest signed values offered, in a binary max-heap.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A query never
// raises busy: its result appears on the out_ ports, flagged by out_valid,
// for one cycle on the cycle after it is taken, so queries may be issued
// every cycle while busy is low; the receiver cannot stall and must take the
// result then. An offer that is ignored also leaves busy low. An insert
// holds busy while it climbs the heap level by level, a root replace while
// it sinks level by level, each ending in the write of the new value; each
// level costs one registered read of the heap RAM followed by a compare and
// write-back through its single write port. The RAM needs no clearing after
// reset. The user must see that capacity is written through cfg_ only while
// the block is idle, which it does not enforce; values above 256 act as 256.
// ---------------------------------------------------------------------------
module k_smallest_tracker_max_heap_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_operation,
  input  logic signed [kst_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  output logic signed [kst_pkg::DATA_W-1:0]  out_kth_value,
  output logic                               out_is_empty,
  output logic [kst_pkg::HELD_W-1:0]         out_held_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kst_pkg::CAP_W-1:0]          cfg_capacity
);

  logic [kst_pkg::CAP_W-1:0]  capacity_r;
  kst_pkg::ram_req_t          ram_req;
  logic [kst_pkg::DATA_W-1:0] rdata_a;
  logic [kst_pkg::DATA_W-1:0] rdata_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= kst_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_capacity;
    end
  end

  kst_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .capacity       (capacity_r),
    .ram_req        (ram_req),
    .rdata_a        (rdata_a),
    .rdata_b        (rdata_b),
    .out_valid      (out_valid),
    .out_kth_value  (out_kth_value),
    .out_is_empty   (out_is_empty),
    .out_held_count (out_held_count)
  );

  kst_ram #(
    .AW (kst_pkg::ADDR_W),
    .DW (kst_pkg::DATA_W)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule

/* tb/sv/k_smallest_tracker_max_heap_checker.sv */
// ---------------------------------------------------------------------------
// k_smallest_tracker_max_heap_checker
// Watches the command, result and capacity channels of the heap tracker. It
// keeps its own max-heap of the k smallest values and checks every query
// result field by field against the report due for it.
// ---------------------------------------------------------------------------
module k_smallest_tracker_max_heap_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               in_operation,
  input  logic signed [kst_pkg::DATA_W-1:0]  in_value,
  input  logic                               out_valid,
  input  logic signed [kst_pkg::DATA_W-1:0]  out_kth_value,
  input  logic                               out_is_empty,
  input  logic [kst_pkg::HELD_W-1:0]         out_held_count,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [kst_pkg::CAP_W-1:0]          cfg_capacity,
  output int                                 mismatch_count,
  output int                                 pending_reports
);

  typedef struct packed {
    logic signed [kst_pkg::DATA_W-1:0] kth;
    logic                              empty;
    logic [kst_pkg::HELD_W-1:0]        held;
  } kth_report_t;

  kth_report_t                       report_queue[$];
  logic signed [kst_pkg::DATA_W-1:0] heap_vals [kst_pkg::DEPTH];
  int unsigned                       held_vals = 0;
  logic [kst_pkg::CAP_W-1:0]         capacity_q = kst_pkg::CAP_RESET;
  int                                errors = 0;

  task automatic note_mismatch(input string field, input longint want, input longint got);
    errors++;
    if (errors <= 10)
      $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, field, want, got);
  endtask

  task automatic sift_in(input logic signed [kst_pkg::DATA_W-1:0] v);
    int unsigned pos;
    int unsigned parent;
    pos = held_vals;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (heap_vals[parent] < v) begin
        heap_vals[pos] = heap_vals[parent];
        pos = parent;
      end else begin
        break;
      end
    end
    heap_vals[pos] = v;
    held_vals++;
  endtask

  task automatic sink_root(input logic signed [kst_pkg::DATA_W-1:0] v);
    int unsigned pos;
    int unsigned child;
    pos = 0;
    forever begin
      child = 2 * pos + 1;
      if (child >= held_vals) break;
      if (child + 1 < held_vals && heap_vals[child] < heap_vals[child + 1]) child++;
      if (heap_vals[child] > v) begin
        heap_vals[pos] = heap_vals[child];
        pos = child;
      end else begin
        break;
      end
    end
    heap_vals[pos] = v;
  endtask

  task automatic offer_value(input logic signed [kst_pkg::DATA_W-1:0] v);
    int unsigned kept;
    kept = (capacity_q > kst_pkg::DEPTH) ? kst_pkg::DEPTH : capacity_q;
    if (held_vals < kept)
      sift_in(v);
    else if (held_vals > 0 && v < heap_vals[0])
      sink_root(v);
  endtask

  always @(posedge clk) begin : monitor
    kth_report_t want;
    kth_report_t due;
    if (!rst_n) begin
      report_queue.delete();
      held_vals  = 0;
      capacity_q = kst_pkg::CAP_RESET;
    end else begin
      // result of an earlier query is taken before this edge's command
      if (out_valid) begin
        if (report_queue.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result at %0t: kth_value %0d is_empty %0b held_count %0d",
                     $realtime, out_kth_value, out_is_empty, out_held_count);
        end else begin
          want = report_queue.pop_front();
          if (out_kth_value !== want.kth) note_mismatch("kth_value", want.kth, out_kth_value);
          if (out_is_empty !== want.empty) note_mismatch("is_empty", want.empty, out_is_empty);
          if (out_held_count !== want.held) note_mismatch("held_count", want.held, out_held_count);
        end
      end
      if (start && !busy) begin
        if (in_operation == kst_pkg::OP_QUERY) begin
          if (held_vals == 0) begin
            due.kth   = kst_pkg::EMPTY_VALUE;
            due.empty = 1'b1;
            due.held  = '0;
          end else begin
            due.kth   = heap_vals[0];
            due.empty = 1'b0;
            due.held  = kst_pkg::HELD_W'(held_vals);
          end
          report_queue.push_back(due);
        end else begin
          offer_value(in_value);
        end
      end
      // a capacity write lands after any command taken at the same edge
      if (cfg_valid && cfg_ready) capacity_q = cfg_capacity;
    end
    mismatch_count  <= errors;
    pending_reports <= report_queue.size();
  end

endmodule

/* tb/sv/k_smallest_tracker_max_heap_top_tb.sv */
// ---------------------------------------------------------------------------
// k_smallest_tracker_max_heap_top_tb
// Drives offers, queries and capacity writes into the heap tracker: a short
// directed opening on the corner cases, then random phases at a range of
// capacities and sender idle rates. Checking is done by the checker module.
// ---------------------------------------------------------------------------
module k_smallest_tracker_max_heap_top_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int NUM_PHASES = 9;
  localparam logic signed [kst_pkg::DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [kst_pkg::DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic                              in_operation;
  logic signed [kst_pkg::DATA_W-1:0] in_value;
  logic                              out_valid;
  logic signed [kst_pkg::DATA_W-1:0] out_kth_value;
  logic                              out_is_empty;
  logic [kst_pkg::HELD_W-1:0]        out_held_count;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [kst_pkg::CAP_W-1:0]         cfg_capacity;

  int mismatch_count;
  int pending_reports;
  int idle_pct;
  int stall_cycles;
  int results_seen = 0;
  int offers_sent;
  int queries_sent;
  int cap_writes;
  logic signed [kst_pkg::DATA_W-1:0] last_kth = '0;

  k_smallest_tracker_max_heap_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_kth_value  (out_kth_value),
    .out_is_empty   (out_is_empty),
    .out_held_count (out_held_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  k_smallest_tracker_max_heap_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_kth_value   (out_kth_value),
    .out_is_empty    (out_is_empty),
    .out_held_count  (out_held_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .mismatch_count  (mismatch_count),
    .pending_reports (pending_reports)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (!out_is_empty) last_kth <= out_kth_value;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_reports);
        $display("FAIL");
        $finish;
      end
    end
  end

  // start stays high across back-to-back commands; idle cycles lower it
  task automatic send_item(input logic op, input logic signed [kst_pkg::DATA_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    do @(posedge clk); while (busy);
    if (op == kst_pkg::OP_QUERY) queries_sent++;
    else offers_sent++;
  endtask

  task automatic offer(input logic signed [kst_pkg::DATA_W-1:0] v);
    send_item(kst_pkg::OP_OFFER, v);
  endtask

  task automatic query();
    send_item(kst_pkg::OP_QUERY, $urandom);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_reports != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [kst_pkg::CAP_W-1:0] c);
    settle();
    cfg_valid    <= 1'b1;
    cfg_capacity <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // mix of full-range, clustered, extreme and just-below-last-kth values
  function automatic logic signed [kst_pkg::DATA_W-1:0] pick_value();
    longint below;
    case ($urandom_range(9))
      0, 1, 2, 3: pick_value = $urandom;
      4, 5:       pick_value = $signed($urandom_range(40)) - 20;
      6: begin
        case ($urandom_range(3))
          0: pick_value = INT_MAX;
          1: pick_value = INT_MIN;
          2: pick_value = -1;
          default: pick_value = 0;
        endcase
      end
      default: begin
        below = longint'(last_kth) - longint'($urandom_range(65536));
        pick_value = (below < longint'(INT_MIN)) ? INT_MIN : kst_pkg::DATA_W'(below);
      end
    endcase
  endfunction

  int cap_plan [NUM_PHASES] = '{7, 511, 3, 256, 0, 300, 1, 64, 256};
  int item_plan [NUM_PHASES] = '{100, 420, 100, 130, 80, 130, 80, 130, 130};

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = kst_pkg::OP_OFFER;
    in_value     = '0;
    cfg_valid    = 1'b0;
    cfg_capacity = kst_pkg::CAP_RESET;
    idle_pct     = 29;
    offers_sent  = 0;
    queries_sent = 0;
    cap_writes   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty query at reset capacity, zero capacity on an empty heap
    query();
    set_capacity(0);
    offer(INT_MAX);
    offer(INT_MIN);
    offer(5);
    query();
    // capacity two: fill, equal to the maximum, replace
    set_capacity(2);
    offer(INT_MAX);
    query();
    offer(INT_MIN);
    query();
    offer(INT_MAX);
    offer(0);
    query();
    offer(-1);
    query();
    // capacity above the heap depth
    set_capacity(511);
    offer(-1);
    offer(INT_MIN);
    offer(INT_MAX);
    offer(0);
    query();
    // capacity lowered below the count held
    set_capacity(1);
    offer(100);
    offer(-7);
    query();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(kst_pkg::CAP_W'(cap_plan[p]));
      idle_pct = (p < 3) ? 29 : (p < 6) ? 62 : 0;
      for (int i = 0; i < item_plan[p]; i++) begin
        if ($urandom_range(3) == 0) query();
        else offer(pick_value());
      end
    end

    settle();
    $display("Sent %0d offers and %0d queries across %0d capacity writes;",
             offers_sent, queries_sent, cap_writes);
    $display("%0d query results compared, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0 && pending_reports == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* k_smallest_tracker_max_heap_top.f */
+incdir+hdl
hdl/kst_pkg.sv
hdl/kst_ram.sv
hdl/kst_ctrl.sv
hdl/k_smallest_tracker_max_heap_top.sv
tb/sv/k_smallest_tracker_max_heap_checker.sv
tb/sv/k_smallest_tracker_max_heap_top_tb.sv
